// ===== sv/djbm_pkg.sv =====
package djbm_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16384;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 48;
  localparam int PRIME_W  = 15;
  localparam int HOLD_W   = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [PRIME_W-1:0] PRIME_RESET = PRIME_W'(960);
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(300000);

  typedef enum logic [1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_POP    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_A    = 2'd1,
    SRC_B    = 2'd2
  } src_t;

  localparam logic [CFG_IDX_W-1:0] REG_MIX_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 2'd2;

  localparam logic POLICY_MIX   = 1'b0;
  localparam logic POLICY_FIRST = 1'b1;

  // frame flag bits
  localparam int FLAG_LIVE_A = 0;
  localparam int FLAG_LIVE_B = 1;
  localparam int FLAG_MIX    = 2;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       frame_start;
    logic [TIME_W-1:0]          time_us;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       accepted;
    logic                       took_a;
    logic                       took_b;
    logic [1:0]                 chosen_source;
  } result_t;

endpackage

// ===== sv/djbm_ram.sv =====
module djbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dual_jitter_buffer_mixer_unit.sv =====
// Two-source audio jitter buffer. A beat is accepted, then answered: in the
// accept cycle the pointers, fill counts and frame decisions are updated and
// the sample memories are addressed; in the next cycle (busy high) the
// registered memory read returns and the output sample is formed. The result
// register then holds the beat for exactly one cycle with done high; the
// receiver cannot stall it, and start may be taken again in that same cycle.
// The sample memories are not cleared; an entry is only read after it has
// been written.
module dual_jitter_buffer_mixer_unit
  import djbm_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (FW > PRIME_W) ? FW : PRIME_W;

  typedef enum logic {ST_IDLE, ST_RESP} state_t;

  typedef struct packed {
    logic       pop;
    logic       mix;
    logic       took_a;
    logic       took_b;
    logic       accepted;
    logic [1:0] chosen;
  } pend_t;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t state;
  pend_t  pend;

  logic                 mix_policy;
  logic [PRIME_W-1:0]   prime_threshold;
  logic [HOLD_W-1:0]    hold_time;

  logic [AW-1:0]     rd_a, wr_a, rd_b, wr_b;
  logic [FW-1:0]     fill_a, fill_b;
  logic              playing_a, playing_b;
  logic [TIME_W-1:0] first_a, first_b, chosen_last_time;
  logic [1:0]        chosen;
  logic [2:0]        frame_flags;

  logic [AW-1:0]     rd_a_next, wr_a_next, rd_b_next, wr_b_next;
  logic [FW-1:0]     fill_a_next, fill_b_next;
  logic              playing_a_next, playing_b_next;
  logic [TIME_W-1:0] first_a_next, first_b_next, chosen_last_time_next;
  logic [1:0]        chosen_next;
  logic [2:0]        frame_flags_next;

  logic              accept;
  logic              we_a, we_b;
  logic              ta, tb, acc;
  logic              ready_a, ready_b, has_a, has_b;
  logic [1:0]        chosen_sel;
  logic [TIME_W-1:0] elapsed;
  logic [SAMPLE_W-1:0] rdata_a, rdata_b;

  logic signed [SAMPLE_W:0]   va, vb, sum;
  logic signed [SAMPLE_W-1:0] sample_calc;

  assign accept = start && !busy;
  assign busy   = (state == ST_RESP);

  assign ready_a = playing_a || (CW'(fill_a) >= CW'(prime_threshold));
  assign ready_b = playing_b || (CW'(fill_b) >= CW'(prime_threshold));
  assign has_a   = (fill_a != '0);
  assign has_b   = (fill_b != '0);
  assign elapsed = item.time_us - chosen_last_time;

  djbm_ram #(.WIDTH(SAMPLE_W), .DEPTH(QUEUE_DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_a),
    .wdata (item.sample_in),
    .raddr (rd_a),
    .rdata (rdata_a)
  );

  djbm_ram #(.WIDTH(SAMPLE_W), .DEPTH(QUEUE_DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_b),
    .wdata (item.sample_in),
    .raddr (rd_b),
    .rdata (rdata_b)
  );

  always_comb begin
    rd_a_next = rd_a;
    wr_a_next = wr_a;
    fill_a_next = fill_a;
    playing_a_next = playing_a;
    rd_b_next = rd_b;
    wr_b_next = wr_b;
    fill_b_next = fill_b;
    playing_b_next = playing_b;
    first_a_next = first_a;
    first_b_next = first_b;
    chosen_last_time_next = chosen_last_time;
    chosen_next = chosen;
    frame_flags_next = frame_flags;
    chosen_sel = chosen;
    we_a = 1'b0;
    we_b = 1'b0;
    ta = 1'b0;
    tb = 1'b0;
    acc = 1'b0;
    if (accept) begin
      case (cmd_t'(item.command))
        CMD_PUSH_A: begin
          if (!has_a) first_a_next = item.time_us;
          if (fill_a != FW'(QUEUE_DEPTH)) begin
            we_a = 1'b1;
            wr_a_next = wrap_inc(wr_a);
            fill_a_next = fill_a + 1'b1;
            acc = 1'b1;
          end
        end
        CMD_PUSH_B: begin
          if (!has_b) first_b_next = item.time_us;
          if (fill_b != FW'(QUEUE_DEPTH)) begin
            we_b = 1'b1;
            wr_b_next = wrap_inc(wr_b);
            fill_b_next = fill_b + 1'b1;
            acc = 1'b1;
          end
        end
        CMD_CLEAR: begin
          rd_a_next = '0;
          wr_a_next = '0;
          fill_a_next = '0;
          playing_a_next = 1'b0;
          rd_b_next = '0;
          wr_b_next = '0;
          fill_b_next = '0;
          playing_b_next = 1'b0;
          first_a_next = '0;
          first_b_next = '0;
          chosen_next = SRC_NONE;
          frame_flags_next = '0;
        end
        CMD_POP: begin
          if (item.frame_start) begin
            if (mix_policy == POLICY_MIX) begin
              // a queue that opens on an empty store drops its playing mark
              ta = ready_a && has_a;
              tb = ready_b && has_b;
              playing_a_next = ta;
              playing_b_next = tb;
              frame_flags_next = {ta && tb, tb, ta};
            end else begin
              if (chosen == SRC_NONE && (ready_a || ready_b)) begin
                if (ready_a && ready_b) begin
                  chosen_sel = (first_a <= first_b) ? SRC_A : SRC_B;
                end else begin
                  chosen_sel = ready_a ? SRC_A : SRC_B;
                end
              end
              if (chosen_sel == SRC_A) begin
                ta = ready_a && has_a;
                playing_a_next = ta;
                if (has_b) begin
                  rd_b_next = '0;
                  wr_b_next = '0;
                  fill_b_next = '0;
                  playing_b_next = 1'b0;
                end
              end else if (chosen_sel == SRC_B) begin
                tb = ready_b && has_b;
                playing_b_next = tb;
                if (has_a) begin
                  rd_a_next = '0;
                  wr_a_next = '0;
                  fill_a_next = '0;
                  playing_a_next = 1'b0;
                end
              end
              frame_flags_next = {1'b0, tb, ta};
              chosen_next = chosen_sel;
              if (ta || tb) begin
                chosen_last_time_next = item.time_us;
              end else if (chosen_sel != SRC_NONE && item.time_us >= chosen_last_time &&
                           elapsed > TIME_W'(hold_time)) begin
                chosen_next = SRC_NONE;
              end
            end
          end else begin
            if (frame_flags[FLAG_LIVE_A]) begin
              if (has_a) begin
                ta = 1'b1;
              end else begin
                playing_a_next = 1'b0;
                frame_flags_next[FLAG_LIVE_A] = 1'b0;
              end
            end
            if (frame_flags[FLAG_LIVE_B]) begin
              if (has_b) begin
                tb = 1'b1;
              end else begin
                playing_b_next = 1'b0;
                frame_flags_next[FLAG_LIVE_B] = 1'b0;
              end
            end
          end
          if (ta) begin
            rd_a_next = wrap_inc(rd_a);
            fill_a_next = fill_a - 1'b1;
          end
          if (tb) begin
            rd_b_next = wrap_inc(rd_b);
            fill_b_next = fill_b - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_a <= '0;
      wr_a <= '0;
      fill_a <= '0;
      playing_a <= 1'b0;
      rd_b <= '0;
      wr_b <= '0;
      fill_b <= '0;
      playing_b <= 1'b0;
      first_a <= '0;
      first_b <= '0;
      chosen_last_time <= '0;
      chosen <= SRC_NONE;
      frame_flags <= '0;
    end else begin
      rd_a <= rd_a_next;
      wr_a <= wr_a_next;
      fill_a <= fill_a_next;
      playing_a <= playing_a_next;
      rd_b <= rd_b_next;
      wr_b <= wr_b_next;
      fill_b <= fill_b_next;
      playing_b <= playing_b_next;
      first_a <= first_a_next;
      first_b <= first_b_next;
      chosen_last_time <= chosen_last_time_next;
      chosen <= chosen_next;
      frame_flags <= frame_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_policy <= POLICY_MIX;
      prime_threshold <= PRIME_RESET;
      hold_time <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIX_POLICY: mix_policy <= cfg_data[0];
        REG_PRIME:      prime_threshold <= cfg_data[PRIME_W-1:0];
        REG_HOLD:       hold_time <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // read data lands in the response cycle; average truncates toward zero
  always_comb begin
    va = pend.took_a ? (SAMPLE_W+1)'($signed(rdata_a)) : '0;
    vb = pend.took_b ? (SAMPLE_W+1)'($signed(rdata_b)) : '0;
    sum = va + vb;
    if (!pend.pop) begin
      sample_calc = '0;
    end else if (pend.mix) begin
      sample_calc = SAMPLE_W'((sum + (SAMPLE_W+1)'(sum[SAMPLE_W])) >>> 1);
    end else if (pend.took_a) begin
      sample_calc = SAMPLE_W'(va);
    end else if (pend.took_b) begin
      sample_calc = SAMPLE_W'(vb);
    end else begin
      sample_calc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RESP;
            pend.pop <= (item.command == CMD_POP);
            pend.mix <= frame_flags_next[FLAG_MIX];
            pend.took_a <= ta;
            pend.took_b <= tb;
            pend.accepted <= acc;
            pend.chosen <= chosen_next;
          end
        end
        ST_RESP: begin
          state <= ST_IDLE;
          done <= 1'b1;
          result.sample_out <= sample_calc;
          result.accepted <= pend.accepted;
          result.took_a <= pend.took_a;
          result.took_b <= pend.took_b;
          result.chosen_source <= pend.chosen;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat did not enter response cycle");

  a_resp_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("response cycle not followed by result strobe");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_a <= FW'(QUEUE_DEPTH) && fill_b <= FW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_push_no_take: assert property (@(posedge clk) disable iff (rst)
    done && result.accepted |-> !result.took_a && !result.took_b)
    else $error("push result reports a take");

  a_chosen_code: assert property (@(posedge clk) disable iff (rst)
    chosen != 2'd3)
    else $error("invalid source choice");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import djbm_pkg::*;

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam int LIMIT_CYCLES = 2000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    item_t      it;
    logic [2:0] gap;
  } beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  item_t                item = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  dual_jitter_buffer_mixer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Jitter buffer / mixer state mirror (index 0 = queue A, 1 = queue B)
  // ---------------------------------------------------------------------------
  logic [15:0]  pcm_store [2][DEPTH];
  logic [13:0]  q_rd [2];
  logic [13:0]  q_wr [2];
  logic [14:0]  q_fill [2];
  logic         q_playing [2];
  logic [47:0]  q_first [2];
  src_t         sel_src;
  logic [47:0]  sel_last_us;
  logic         live_a, live_b, frame_avg;
  logic         cfg_policy;
  logic [14:0]  cfg_prime;
  logic [23:0]  cfg_hold;

  function automatic void q_flush(int q);
    q_rd[q] = '0;
    q_wr[q] = '0;
    q_fill[q] = '0;
    q_playing[q] = 1'b0;
  endfunction

  function automatic logic q_push(int q, logic [15:0] v, logic [47:0] now);
    if (q_fill[q] == 0) q_first[q] = now;
    if (q_fill[q] >= DEPTH) return 1'b0;  // full: drop
    pcm_store[q][q_wr[q]] = v;
    q_wr[q] = q_wr[q] + 14'd1;
    q_fill[q] = q_fill[q] + 15'd1;
    return 1'b1;
  endfunction

  function automatic logic q_take(int q, output logic [15:0] v);
    v = '0;
    if (q_fill[q] == 0) begin
      q_playing[q] = 1'b0;  // underrun
      return 1'b0;
    end
    v = pcm_store[q][q_rd[q]];
    q_rd[q] = q_rd[q] + 14'd1;
    q_fill[q] = q_fill[q] - 15'd1;
    return 1'b1;
  endfunction

  function automatic logic q_open(int q, output logic [15:0] v);
    v = '0;
    if (!q_playing[q]) begin
      if (q_fill[q] < cfg_prime) return 1'b0;
      q_playing[q] = 1'b1;
    end
    return q_take(q, v);
  endfunction

  function automatic result_t mix_next(item_t it);
    result_t     r;
    logic [15:0] sa, sb;
    logic        ta, tb, ra, rb;
    int          va, vb;
    r = '0;
    sa = '0;
    sb = '0;
    ta = 1'b0;
    tb = 1'b0;
    case (it.command)
      CMD_PUSH_A: r.accepted = q_push(0, it.sample_in, it.time_us);
      CMD_PUSH_B: r.accepted = q_push(1, it.sample_in, it.time_us);
      CMD_CLEAR: begin
        q_flush(0);
        q_flush(1);
        q_first[0] = '0;
        q_first[1] = '0;
        sel_src = SRC_NONE;
        {live_a, live_b, frame_avg} = '0;
      end
      default: begin
        if (it.frame_start) begin
          {live_a, live_b, frame_avg} = '0;
          if (cfg_policy == POLICY_MIX) begin
            ta = q_open(0, sa);
            tb = q_open(1, sb);
            live_a = ta;
            live_b = tb;
            frame_avg = ta && tb;
          end else begin
            ra = q_playing[0] || q_fill[0] >= cfg_prime;
            rb = q_playing[1] || q_fill[1] >= cfg_prime;
            if (sel_src == SRC_NONE && (ra || rb)) begin
              if (ra && rb) sel_src = (q_first[0] <= q_first[1]) ? SRC_A : SRC_B;
              else sel_src = ra ? SRC_A : SRC_B;
            end
            if (sel_src == SRC_A) begin
              ta = q_open(0, sa);
              if (q_fill[1] > 0) q_flush(1);
              live_a = ta;
            end else if (sel_src == SRC_B) begin
              tb = q_open(1, sb);
              if (q_fill[0] > 0) q_flush(0);
              live_b = tb;
            end
            if (ta || tb) begin
              sel_last_us = it.time_us;
            end else if (sel_src != SRC_NONE && it.time_us >= sel_last_us &&
                         it.time_us - sel_last_us > cfg_hold) begin
              sel_src = SRC_NONE;
            end
          end
        end else begin
          if (live_a) begin
            ta = q_take(0, sa);
            if (!ta) live_a = 1'b0;
          end
          if (live_b) begin
            tb = q_take(1, sb);
            if (!tb) live_b = 1'b0;
          end
        end
      end
    endcase
    if (it.command == CMD_POP) begin
      va = ta ? int'($signed(sa)) : 0;
      vb = tb ? int'($signed(sb)) : 0;
      // averaged frames keep dividing by two even after one side ran dry
      if (frame_avg) r.sample_out = 16'((va + vb) / 2);
      else if (ta) r.sample_out = sa;
      else if (tb) r.sample_out = sb;
    end
    r.took_a = ta;
    r.took_b = tb;
    r.chosen_source = sel_src;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  beat_t   cmd_q[$];
  result_t pending_out[$];
  beat_t   cur = '0;
  bit      staged = 1'b0;
  bit      presenting = 1'b0;
  int      drv_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item <= '0;
      staged = 1'b0;
      presenting = 1'b0;
      drv_wait = 0;
    end else begin
      if (start && !busy) begin
        pending_out.push_back(mix_next(item));
        presenting = 1'b0;
      end
      if (!presenting && !staged && cmd_q.size() != 0) begin
        cur = cmd_q.pop_front();
        staged = 1'b1;
        drv_wait = cur.gap;
      end
      if (staged) begin
        if (drv_wait == 0) begin
          presenting = 1'b1;
          staged = 1'b0;
        end else begin
          drv_wait--;
        end
      end
      start <= presenting;
      item <= cur.it;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  int      fail_count = 0;
  result_t want;

  task automatic check_field(string name, logic signed [31:0] exp_v,
                             logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_out.size() == 0) begin
        $error("result beat with nothing outstanding");
        fail_count++;
      end else begin
        want = pending_out.pop_front();
        check_field("sample_out", 32'($signed(want.sample_out)),
                    32'($signed(result.sample_out)));
        check_field("accepted", 32'(want.accepted), 32'(result.accepted));
        check_field("took_a", 32'(want.took_a), 32'(result.took_a));
        check_field("took_b", 32'(want.took_b), 32'(result.took_b));
        check_field("chosen_source", 32'(want.chosen_source),
                    32'(result.chosen_source));
      end
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("dual_jitter_buffer_mixer_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [47:0] clock_us = '0;
  int          time_step_max = 0;
  bit          no_gaps = 1'b0;

  task automatic send(cmd_t c, logic [15:0] s, logic fs);
    beat_t b;
    int    r;
    if (time_step_max > 0) begin
      r = $urandom_range(0, 99);
      if (r == 0) clock_us = clock_us - 48'($urandom_range(0, 50));
      else if (r < 3) clock_us = clock_us + 48'($urandom_range(0, 400));
      else clock_us = clock_us + 48'($urandom_range(0, time_step_max));
    end
    b.it.command = c;
    b.it.sample_in = s;
    b.it.frame_start = fs;
    b.it.time_us = clock_us;
    b.gap = no_gaps ? 3'd0 : 3'($urandom_range(0, 6));
    cmd_q.push_back(b);
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || staged || presenting || pending_out.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_MIX_POLICY: cfg_policy = data[0];
      REG_PRIME:      cfg_prime = data[PRIME_W-1:0];
      REG_HOLD:       cfg_hold = data[HOLD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly push bursts followed by a pop frame, plus stray commands and clears
  task automatic gen_traffic(int n_beats);
    int made, na, nb, nf, r;
    made = 0;
    while (made < n_beats) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        na = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        nb = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        while (na + nb > 0) begin
          if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 1)) begin
            send(CMD_PUSH_A, 16'($urandom), 1'($urandom_range(0, 1)));
            na--;
          end else begin
            send(CMD_PUSH_B, 16'($urandom), 1'($urandom_range(0, 1)));
            nb--;
          end
          made++;
        end
        nf = $urandom_range(1, 8);
        for (int k = 0; k < nf; k++) begin
          send(CMD_POP, 16'($urandom), k == 0);
          made++;
        end
      end else if (r < 96) begin
        send(cmd_t'($urandom_range(0, 2)), 16'($urandom), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        send(CMD_CLEAR, 16'($urandom), 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  task automatic run_phase(logic policy, logic [CFG_W-1:0] prime,
                           logic [CFG_W-1:0] hold, int n_beats);
    write_reg(REG_MIX_POLICY, CFG_W'(policy));
    write_reg(REG_PRIME, prime);
    write_reg(REG_HOLD, hold);
    gen_traffic(n_beats);
    drain();
  endtask

  initial begin
    cfg_policy = POLICY_MIX;
    cfg_prime = PRIME_RESET;
    cfg_hold = HOLD_RESET;
    q_flush(0);
    q_flush(1);
    q_first[0] = '0;
    q_first[1] = '0;
    sel_src = SRC_NONE;
    sel_last_us = '0;
    {live_a, live_b, frame_avg} = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // out-of-frame pops and an unprimed queue under the reset settings
    send(CMD_POP, 16'h1234, 1'b0);
    send(CMD_POP, 16'h0000, 1'b1);
    send(CMD_PUSH_A, 16'h8000, 1'b0);
    send(CMD_POP, 16'hFFFF, 1'b1);
    send(CMD_CLEAR, 16'h0000, 1'b0);
    drain();

    // averaging: negative odd sum truncates toward zero, then underrun
    write_reg(REG_MIX_POLICY, CFG_W'(POLICY_MIX));
    write_reg(REG_PRIME, 24'd1);
    write_reg(REG_HOLD, 24'd0);
    send(CMD_PUSH_A, 16'h8000, 1'b0);
    send(CMD_PUSH_B, 16'h8001, 1'b1);
    send(CMD_PUSH_A, 16'h7FFF, 1'b0);
    send(CMD_PUSH_B, 16'h0000, 1'b0);
    send(CMD_POP, 16'h0000, 1'b1);
    send(CMD_POP, 16'h0000, 1'b0);
    send(CMD_POP, 16'h0000, 1'b0);
    send(CMD_POP, 16'h0000, 1'b0);
    drain();

    // first-come: earlier B wins, A flushed, hold release, time going back
    write_reg(REG_MIX_POLICY, CFG_W'(POLICY_FIRST));
    write_reg(REG_PRIME, 24'd2);
    write_reg(REG_HOLD, 24'd5);
    clock_us = 48'd100;
    send(CMD_PUSH_B, 16'h0101, 1'b0);
    clock_us = 48'd101;
    send(CMD_PUSH_A, 16'h0202, 1'b0);
    send(CMD_PUSH_A, 16'h0303, 1'b0);
    send(CMD_PUSH_B, 16'hFEFE, 1'b0);
    clock_us = 48'd102;
    send(CMD_POP, 16'h0000, 1'b1);
    clock_us = 48'd103;
    send(CMD_POP, 16'h0000, 1'b1);
    clock_us = 48'd104;
    send(CMD_POP, 16'h0000, 1'b1);
    clock_us = 48'd110;
    send(CMD_POP, 16'h0000, 1'b1);
    clock_us = '1;
    send(CMD_PUSH_A, 16'h5A5A, 1'b0);
    send(CMD_PUSH_A, 16'hA5A5, 1'b0);
    send(CMD_POP, 16'h0000, 1'b1);
    send(CMD_POP, 16'h0000, 1'b1);
    clock_us = 48'd5;
    send(CMD_POP, 16'h0000, 1'b1);
    send(CMD_CLEAR, 16'h0000, 1'b1);
    drain();

    time_step_max = 8;

    run_phase(POLICY_MIX, 24'd0, 24'd0, 150);
    run_phase(POLICY_FIRST, 24'd0, 24'd0, 150);
    run_phase(POLICY_FIRST, 24'd3, 24'd20, 150);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    run_phase(POLICY_MIX, 24'd4, 24'hFFFFFF, 150);
    run_phase(POLICY_FIRST, CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(0, 100)),
              150);
    // threshold above the queue depth: nothing ever starts
    run_phase(POLICY_FIRST, 24'hFFFFFF, CFG_W'($urandom_range(0, 60)), 150);
    clock_us = 48'hFFFF_FFFF_FC00;
    run_phase(POLICY_MIX, 24'd2, CFG_W'($urandom), 150);
    clock_us = 48'({$urandom, $urandom});
    run_phase(POLICY_FIRST, 24'd5, CFG_W'($urandom_range(0, 200)), 150);

    if (fail_count == 0) begin
      $display("dual_jitter_buffer_mixer_unit test passed");
    end else begin
      $display("dual_jitter_buffer_mixer_unit test failed");
    end
    $finish;
  end

endmodule
